/* rtl/core/tsrt_pkg.sv */
package tsrt_pkg;

    localparam int MODE_W     = 3;
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 160;
    localparam int SLOT_OUT_W = 4;

    localparam int OUT_FOUND_BIT = 0;
    localparam int OUT_EV_BIT    = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD         = 3'd0,
        MODE_FIND_LOCAL  = 3'd1,
        MODE_FIND_REMOTE = 3'd2,
        MODE_FIND_OLDER  = 3'd3,
        MODE_CLEAR       = 3'd4
    } t_mode;

    typedef struct packed {
        logic               flight_present;
        logic signed [31:0] flight_time;
        logic               rx_present;
        logic [39:0]        rx_time;
        logic               tx_present;
        logic [39:0]        tx_time;
        logic [15:0]        remote_seq;
        logic [15:0]        local_seq;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

endpackage

/* rtl/core/timestamp_record_table_unit.sv */
// Ranging record table. Each request carries a mode in tuser: add/update, find by local
// sequence, find by remote sequence, find the newest complete record older than a local
// sequence, or clear. Every request returns exactly one result. Records live in one
// synchronous table memory together with a link to the next older record; a second small
// memory holds the ring of free slots. A request walks the list from newest to oldest and
// visits one record per cycle, bounded by the table memory's single registered read port.
// A lookup stops at its first hit; an add on a full table walks the whole list
// (TABLE_DEPTH records) to find the new oldest record. Clear, an unused mode or a lookup
// on an empty table goes straight to its result, and an add on an empty table straight
// to its write. A stalled result does not keep the next request from being taken, but
// that request's result waits for it. No clearing pass is needed after reset or clear.
module timestamp_record_table_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // local_seq, remote_seq, tx_time, tx_present, rx_time, rx_present,
    // flight_time, flight_present
    input  logic [tsrt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // mode
    input  logic [tsrt_pkg::MODE_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // found, slot, evicted, out_local_seq, out_remote_seq, out_tx_time, out_tx_present,
    // out_rx_time, out_rx_present, out_flight_time, out_flight_present
    output logic [tsrt_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import tsrt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef logic [AW-1:0] t_slot;
    typedef logic [CW-1:0] t_cnt;

    localparam t_slot LAST_SLOT = t_slot'(TABLE_DEPTH - 1);
    localparam t_cnt  FULL_CNT  = t_cnt'(TABLE_DEPTH);

    typedef struct packed {
        t_slot older;
        t_rec  rec;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_WRITE,
        S_EMIT
    } t_state;

    t_entry r_tab [TABLE_DEPTH];
    t_entry r_tab_q;
    t_slot  r_ring [TABLE_DEPTH];
    t_slot  r_ring_q;

    t_state              r_state, n_state;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic                r_evict, n_evict;
    logic                r_hit, n_hit;
    logic                r_out_valid, n_out_valid;
    t_slot               r_newest, n_newest;
    t_slot               r_oldest, n_oldest;
    t_slot               r_rd_ptr, n_rd_ptr;
    t_slot               r_wr_ptr, n_wr_ptr;
    t_cnt                r_free_cnt, n_free_cnt;
    t_cnt                r_fill, n_fill;

    t_rec                r_in, n_in;
    t_slot               r_cur, n_cur;
    t_slot               r_prev, n_prev;
    t_slot               r_hit_slot, n_hit_slot;
    t_slot               r_hit_older, n_hit_older;
    logic                r_res_found, n_res_found;
    logic                r_res_ev, n_res_ev;
    t_slot               r_res_slot, n_res_slot;
    t_rec                r_res_rec, n_res_rec;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic   out_load;
    t_slot  tab_raddr;
    logic   tab_we;
    t_slot  tab_waddr;
    t_entry tab_wdata;
    logic   ring_we;
    t_slot  ring_waddr;
    t_slot  rd_inc;
    t_slot  wr_inc;
    t_slot  ring_val;
    logic   list_empty;
    t_rec   in_raw;
    t_rec   in_clean;

    assign rd_inc     = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
    assign wr_inc     = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
    assign ring_waddr = wr_inc;
    assign ring_val   = (t_cnt'(r_rd_ptr) < r_fill) ? r_ring_q : r_rd_ptr;
    assign list_empty = (r_free_cnt == FULL_CNT);

    assign in_raw = s_axis_tdata[REC_W-1:0];

    always_comb begin
        in_clean = in_raw;
        if (!in_raw.tx_present) begin
            in_clean.tx_time = '0;
        end
        if (!in_raw.rx_present) begin
            in_clean.rx_time = '0;
        end
        if (!in_raw.flight_present) begin
            in_clean.flight_time = '0;
        end
    end

    always_comb begin
        t_entry rd_ent;
        logic   match;
        t_rec   merged;
        t_slot  new_slot;
        logic   empties;

        rd_ent   = r_tab_q;
        merged   = r_res_rec;
        new_slot = r_evict ? r_oldest : ring_val;
        empties  = r_evict ? (r_oldest == r_newest) : list_empty;

        n_state     = r_state;
        n_mode      = r_mode;
        n_evict     = r_evict;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_newest    = r_newest;
        n_oldest    = r_oldest;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_free_cnt  = r_free_cnt;
        n_fill      = r_fill;
        n_in        = r_in;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_hit_slot  = r_hit_slot;
        n_hit_older = r_hit_older;
        n_res_found = r_res_found;
        n_res_ev    = r_res_ev;
        n_res_slot  = r_res_slot;
        n_res_rec   = r_res_rec;

        out_load  = 1'b0;
        tab_raddr = r_newest;
        tab_we    = 1'b0;
        tab_waddr = r_hit_slot;
        tab_wdata = '0;
        ring_we   = 1'b0;

        s_axis_tready = (r_state == S_IDLE);

        case (r_mode)
            MODE_ADD, MODE_FIND_LOCAL: match = (rd_ent.rec.local_seq == r_in.local_seq);
            MODE_FIND_REMOTE:          match = (rd_ent.rec.remote_seq == r_in.remote_seq);
            MODE_FIND_OLDER:           match = (rd_ent.rec.local_seq < r_in.local_seq) &&
                                               rd_ent.rec.tx_present && rd_ent.rec.rx_present;
            default:                   match = 1'b0;
        endcase

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_in        = in_clean;
                    n_mode      = s_axis_tuser;
                    n_hit       = 1'b0;
                    n_evict     = (s_axis_tuser == MODE_ADD) && (r_free_cnt == '0);
                    n_cur       = r_newest;
                    n_res_found = 1'b0;
                    n_res_ev    = 1'b0;
                    n_res_slot  = '0;
                    n_res_rec   = '0;
                    case (s_axis_tuser)
                        MODE_ADD: begin
                            if (list_empty ||
                                ((r_free_cnt == '0) && (r_oldest == r_newest))) begin
                                n_state = S_WRITE;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        MODE_FIND_LOCAL, MODE_FIND_REMOTE, MODE_FIND_OLDER: begin
                            n_state = list_empty ? S_EMIT : S_WALK;
                        end
                        MODE_CLEAR: begin
                            n_free_cnt = FULL_CNT;
                            n_rd_ptr   = '0;
                            n_wr_ptr   = LAST_SLOT;
                            n_fill     = '0;
                            n_newest   = '0;
                            n_oldest   = '0;
                            n_state    = S_EMIT;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_WALK: begin
                tab_raddr = rd_ent.older;
                if (r_evict) begin
                    // the oldest record is dropped, so it is never tested
                    if (r_cur == r_oldest) begin
                        n_state = S_WRITE;
                    end else begin
                        if (match && !r_hit) begin
                            n_hit       = 1'b1;
                            n_hit_slot  = r_cur;
                            n_hit_older = rd_ent.older;
                            n_res_rec   = rd_ent.rec;
                        end
                        n_prev = r_cur;
                        n_cur  = rd_ent.older;
                    end
                end else if (match) begin
                    n_hit       = 1'b1;
                    n_hit_slot  = r_cur;
                    n_hit_older = rd_ent.older;
                    n_res_rec   = rd_ent.rec;
                    n_res_found = 1'b1;
                    n_res_slot  = r_cur;
                    n_state     = (r_mode == MODE_ADD) ? S_WRITE : S_EMIT;
                end else if (r_cur == r_oldest) begin
                    n_state = (r_mode == MODE_ADD) ? S_WRITE : S_EMIT;
                end else begin
                    n_cur = rd_ent.older;
                end
            end
            S_WRITE: begin
                n_res_found = 1'b1;
                n_res_ev    = r_evict;
                if (r_evict) begin
                    if (r_oldest != r_newest) begin
                        n_oldest = r_prev;
                    end
                    ring_we  = 1'b1;
                    n_wr_ptr = wr_inc;
                    n_fill   = (r_fill == FULL_CNT) ? r_fill : r_fill + 1'b1;
                end
                if (r_hit) begin
                    if (r_in.tx_present) begin
                        merged.tx_present = 1'b1;
                        merged.tx_time    = r_in.tx_time;
                    end
                    if (r_in.rx_present) begin
                        merged.rx_present = 1'b1;
                        merged.rx_time    = r_in.rx_time;
                    end
                    if (r_in.flight_present) begin
                        merged.flight_present = 1'b1;
                        merged.flight_time    = r_in.flight_time;
                    end
                    tab_we           = 1'b1;
                    tab_waddr        = r_hit_slot;
                    tab_wdata.older  = r_hit_older;
                    tab_wdata.rec    = merged;
                    n_res_slot       = r_hit_slot;
                    n_res_rec        = merged;
                    n_free_cnt       = r_evict ? r_free_cnt + 1'b1 : r_free_cnt;
                end else begin
                    tab_we          = 1'b1;
                    tab_waddr       = new_slot;
                    tab_wdata.older = r_newest;
                    tab_wdata.rec   = r_in;
                    n_newest        = new_slot;
                    if (empties) begin
                        n_oldest = new_slot;
                    end
                    n_rd_ptr   = rd_inc;
                    n_free_cnt = r_evict ? r_free_cnt : r_free_cnt - 1'b1;
                    n_res_slot = new_slot;
                    n_res_rec  = r_in;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_CLEAR;
            r_evict     <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            r_newest    <= '0;
            r_oldest    <= '0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= LAST_SLOT;
            r_free_cnt  <= FULL_CNT;
            r_fill      <= '0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_evict     <= n_evict;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
            r_newest    <= n_newest;
            r_oldest    <= n_oldest;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_free_cnt  <= n_free_cnt;
            r_fill      <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in        <= n_in;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_hit_slot  <= n_hit_slot;
        r_hit_older <= n_hit_older;
        r_res_found <= n_res_found;
        r_res_ev    <= n_res_ev;
        r_res_slot  <= n_res_slot;
        r_res_rec   <= n_res_rec;
        if (out_load) begin
            r_out_data <= OUT_DATA_W'({r_res_rec, r_res_ev,
                                       SLOT_OUT_W'(r_res_slot), r_res_found});
        end
    end

    // record table with older link, one write and one read port
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[tab_waddr] <= tab_wdata;
        end
        r_tab_q <= r_tab[tab_raddr];
    end

    // free slot ring, entries beyond the fill count read as their own index
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_waddr] <= r_oldest;
        end
        r_ring_q <= r_ring[r_rd_ptr];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* rtl/core/tsrt_checker.sv */
module tsrt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tsrt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import tsrt_pkg::*;

    // one request at a time
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in work");

    // a miss carries no record contents
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[OUT_FOUND_BIT] |->
        m_axis_tdata[OUT_DATA_W-1:1] == '0)
        else $error("miss result carries data");

    a_evict_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_EV_BIT] |-> m_axis_tdata[OUT_FOUND_BIT])
        else $error("eviction without a written record");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind timestamp_record_table_unit tsrt_checker u_tsrt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* test/timestamp_record_table_unit_tb.sv */
module timestamp_record_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsrt_pkg::*;

    localparam int DEPTH = 16;
    localparam int NIL = DEPTH;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES = 60;
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST = 3'd7;

    typedef struct packed {
        logic [6:0]         pad;
        logic               flight_present;
        logic signed [31:0] flight_time;
        logic               rx_present;
        logic [39:0]        rx_time;
        logic               tx_present;
        logic [39:0]        tx_time;
        logic [15:0]        remote_seq;
        logic [15:0]        local_seq;
        logic               evicted;
        logic [3:0]         slot;
        logic               found;
    } lookup_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data = '0;   // local_seq, remote_seq, tx_time, tx_present,
                                          // rx_time, rx_present, flight_time, flight_present
    logic [MODE_W-1:0]     s_user = '0;   // mode
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;        // found, slot, evicted, local_seq, remote_seq,
                                          // tx_time, tx_present, rx_time, rx_present,
                                          // flight_time, flight_present

    timestamp_record_table_unit #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow copy of the record table
    logic [15:0] tbl_local [DEPTH];
    logic [15:0] tbl_remote [DEPTH];
    logic [40:0] tbl_tx [DEPTH];
    logic [40:0] tbl_rx [DEPTH];
    logic [32:0] tbl_flight [DEPTH];
    int          older_link [DEPTH];
    int          newer_link [DEPTH];
    int          head_slot, tail_slot;
    int          free_slots [DEPTH];
    int          free_rd, free_wr, free_cnt;

    lookup_result_t pending_results[$];
    logic [15:0]    recent_local[$];
    logic [15:0]    recent_remote[$];

    bit tx_gaps_on = 1'b1;
    bit rx_stalls_on = 1'b1;
    int hold_off_req = 0;
    int mismatches = 0;
    int results_checked = 0;
    int n_add = 0, n_lookup = 0, n_clear = 0, n_spare = 0, n_evict = 0, n_hits = 0;

    function automatic void table_init();
        for (int i = 0; i < DEPTH; i++) begin
            tbl_local[i] = '0;
            tbl_remote[i] = '0;
            tbl_tx[i] = '0;
            tbl_rx[i] = '0;
            tbl_flight[i] = '0;
            older_link[i] = NIL;
            newer_link[i] = NIL;
            free_slots[i] = i;
        end
        head_slot = NIL;
        tail_slot = NIL;
        free_rd = 0;
        free_wr = DEPTH - 1;
        free_cnt = DEPTH;
    endfunction

    function automatic void free_push(input int s);
        if (free_cnt >= DEPTH) return;
        free_wr = (free_wr + 1) % DEPTH;
        free_slots[free_wr] = s;
        free_cnt++;
    endfunction

    function automatic int free_pop();
        int s;
        if (free_cnt == 0) return NIL;
        s = free_slots[free_rd];
        free_rd = (free_rd + 1) % DEPTH;
        free_cnt--;
        return s;
    endfunction

    function automatic bit drop_oldest();
        int s;
        int p;
        s = tail_slot;
        if (s >= DEPTH) return 1'b0;
        p = newer_link[s];
        tail_slot = p;
        if (p < DEPTH) older_link[p] = NIL;
        else head_slot = NIL;
        tbl_local[s] = '0;
        tbl_remote[s] = '0;
        tbl_tx[s] = '0;
        tbl_rx[s] = '0;
        tbl_flight[s] = '0;
        older_link[s] = NIL;
        newer_link[s] = NIL;
        free_push(s);
        return 1'b1;
    endfunction

    function automatic int walk_list(input t_mode kind, input logic [15:0] key);
        int s;
        s = head_slot;
        for (int n = 0; n < DEPTH && s < DEPTH; n++) begin
            case (kind)
                MODE_FIND_LOCAL:  if (tbl_local[s] == key) return s;
                MODE_FIND_REMOTE: if (tbl_remote[s] == key) return s;
                MODE_FIND_OLDER:
                    if (tbl_local[s] < key && tbl_tx[s][40] && tbl_rx[s][40]) return s;
                default: ;
            endcase
            s = older_link[s];
        end
        return NIL;
    endfunction

    function automatic lookup_result_t make_result(input int s, input bit ev);
        lookup_result_t res;
        res = '0;
        res.evicted = ev;
        if (s >= DEPTH) return res;
        res.found = 1'b1;
        res.slot = s[3:0];
        res.local_seq = tbl_local[s];
        res.remote_seq = tbl_remote[s];
        res.tx_time = tbl_tx[s][39:0];
        res.tx_present = tbl_tx[s][40];
        res.rx_time = tbl_rx[s][39:0];
        res.rx_present = tbl_rx[s][40];
        res.flight_time = tbl_flight[s][31:0];
        res.flight_present = tbl_flight[s][32];
        return res;
    endfunction

    function automatic lookup_result_t table_apply(input logic [MODE_W-1:0] mode,
                                                   input t_rec r);
        logic [40:0] txv;
        logic [40:0] rxv;
        logic [32:0] tfv;
        int          s;
        bit          ev;
        txv = r.tx_present ? {1'b1, r.tx_time} : '0;
        rxv = r.rx_present ? {1'b1, r.rx_time} : '0;
        tfv = r.flight_present ? {1'b1, r.flight_time} : '0;
        ev = 1'b0;
        case (mode)
            MODE_ADD: begin
                if (free_cnt == 0) ev = drop_oldest();
                s = walk_list(MODE_FIND_LOCAL, r.local_seq);
                if (s != NIL) begin
                    if (r.tx_present) tbl_tx[s] = txv;
                    if (r.rx_present) tbl_rx[s] = rxv;
                    if (r.flight_present) tbl_flight[s] = tfv;
                end else begin
                    s = free_pop();
                    if (s != NIL) begin
                        tbl_local[s] = r.local_seq;
                        tbl_remote[s] = r.remote_seq;
                        tbl_tx[s] = txv;
                        tbl_rx[s] = rxv;
                        tbl_flight[s] = tfv;
                        newer_link[s] = NIL;
                        if (head_slot >= DEPTH) begin
                            older_link[s] = NIL;
                            tail_slot = s;
                        end else begin
                            newer_link[head_slot] = s;
                            older_link[s] = head_slot;
                        end
                        head_slot = s;
                    end
                end
                return make_result(s, ev);
            end
            MODE_FIND_LOCAL:  return make_result(walk_list(MODE_FIND_LOCAL, r.local_seq), 0);
            MODE_FIND_REMOTE: return make_result(walk_list(MODE_FIND_REMOTE, r.remote_seq), 0);
            MODE_FIND_OLDER:  return make_result(walk_list(MODE_FIND_OLDER, r.local_seq), 0);
            MODE_CLEAR: begin
                table_init();
                return make_result(NIL, 0);
            end
            default: return make_result(NIL, 0);
        endcase
    endfunction

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic t_rec build_rec(input logic [15:0] lseq, input logic [15:0] rseq,
                                       input logic txp, input logic [39:0] tx,
                                       input logic rxp, input logic [39:0] rx,
                                       input logic fp, input logic [31:0] ft);
        t_rec r;
        r.local_seq = lseq;
        r.remote_seq = rseq;
        r.tx_present = txp;
        r.tx_time = tx;
        r.rx_present = rxp;
        r.rx_time = rx;
        r.flight_present = fp;
        r.flight_time = ft;
        return r;
    endfunction

    function automatic t_rec random_rec(input logic [15:0] lseq, input logic [15:0] rseq);
        logic [63:0] tx;
        logic [63:0] rx;
        tx = {$urandom, $urandom};
        rx = {$urandom, $urandom};
        return build_rec(lseq, rseq, $urandom_range(0, 9) < 7, tx[39:0],
                         $urandom_range(0, 9) < 7, rx[39:0],
                         $urandom_range(0, 9) < 6, $urandom);
    endfunction

    function automatic logic [15:0] pick_seq(ref logic [15:0] pool[$]);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && pool.size() > 0) return pool[$urandom_range(0, pool.size() - 1)];
        if (r < 70) return 16'($urandom_range(0, 63));
        if (r < 75) return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
        return 16'($urandom);
    endfunction

    task automatic send_request(input logic [MODE_W-1:0] mode, input t_rec r);
        lookup_result_t want;
        int             gap;
        gap = (tx_gaps_on && $urandom_range(0, 99) < 30) ? pick_pause() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user <= mode;
        s_data <= IN_DATA_W'(r);
        do @(posedge clk); while (!s_ready);
        want = table_apply(mode, r);
        pending_results.push_back(want);
        case (mode)
            MODE_ADD: begin
                n_add++;
                if (want.evicted) n_evict++;
                recent_local.push_back(r.local_seq);
                recent_remote.push_back(r.remote_seq);
                if (recent_local.size() > 24) begin
                    void'(recent_local.pop_front());
                    void'(recent_remote.pop_front());
                end
            end
            MODE_FIND_LOCAL, MODE_FIND_REMOTE, MODE_FIND_OLDER: begin
                n_lookup++;
                if (want.found) n_hits++;
            end
            MODE_CLEAR: n_clear++;
            default: n_spare++;
        endcase
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch on %s: expected %h, got %h", $realtime, name, want, got);
        end
    endfunction

    task automatic check_result(input lookup_result_t got);
        lookup_result_t want;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("%0t result with no request pending: %h",
                                           $realtime, got);
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        compare_field("found", want.found, got.found);
        compare_field("slot", want.slot, got.slot);
        compare_field("evicted", want.evicted, got.evicted);
        compare_field("local_seq", want.local_seq, got.local_seq);
        compare_field("remote_seq", want.remote_seq, got.remote_seq);
        compare_field("tx_time", want.tx_time, got.tx_time);
        compare_field("tx_present", want.tx_present, got.tx_present);
        compare_field("rx_time", want.rx_time, got.rx_time);
        compare_field("rx_present", want.rx_present, got.rx_present);
        compare_field("flight_time", 64'(unsigned'(want.flight_time)),
                      64'(unsigned'(got.flight_time)));
        compare_field("flight_present", want.flight_present, got.flight_present);
    endtask

    // empty-table lookups, field extremes, in-place updates, spare modes, clear
    task automatic test_directed();
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        send_request(MODE_FIND_LOCAL, random_rec(16'h0000, 16'h0000));
        send_request(MODE_FIND_REMOTE, random_rec(16'h0000, 16'h0000));
        send_request(MODE_FIND_OLDER, random_rec(16'hffff, 16'hffff));
        send_request(MODE_ADD, build_rec(16'h0000, 16'hffff, 1'b0, noise[39:0],
                                         1'b0, ~noise[39:0], 1'b0, noise[63:32]));
        send_request(MODE_ADD, build_rec(16'hffff, 16'h0000, 1'b1, '1, 1'b1, '1,
                                         1'b1, 32'h7fffffff));
        send_request(MODE_ADD, build_rec(16'h1234, 16'h5678, 1'b0, '1, 1'b1, '0,
                                         1'b1, 32'h80000000));
        send_request(MODE_ADD, build_rec(16'h0000, 16'h1111, 1'b1, 40'haaaaaaaaaa,
                                         1'b0, '1, 1'b1, 32'hffffffff));
        send_request(MODE_ADD, build_rec(16'h1234, 16'h2222, 1'b1, 40'h5555555555,
                                         1'b0, '1, 1'b0, '1));
        send_request(MODE_FIND_LOCAL, random_rec(16'hffff, 16'h0000));
        send_request(MODE_FIND_LOCAL, random_rec(16'h4321, 16'h0000));
        send_request(MODE_FIND_REMOTE, random_rec(16'h0000, 16'hffff));
        send_request(MODE_FIND_REMOTE, random_rec(16'h0000, 16'h0000));
        send_request(MODE_FIND_OLDER, random_rec(16'hffff, 16'h0000));
        send_request(MODE_FIND_OLDER, random_rec(16'h0000, 16'h0000));
        send_request(MODE_FIND_OLDER, random_rec(16'h1234, 16'h0000));
        for (logic [MODE_W-1:0] m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
            send_request(m, random_rec(16'hffff, 16'hffff));
            if (m == MODE_SPARE_LAST) break;
        end
        send_request(MODE_FIND_LOCAL, random_rec(16'hffff, 16'h0000));
        send_request(MODE_CLEAR, random_rec(16'hffff, 16'hffff));
        send_request(MODE_FIND_LOCAL, random_rec(16'hffff, 16'h0000));
        send_request(MODE_ADD, build_rec(16'h0007, 16'h0070, 1'b1, noise[39:0],
                                         1'b1, noise[63:24], 1'b0, '0));
        send_request(MODE_FIND_OLDER, random_rec(16'h0008, 16'h0000));
        wait_for_drain();
    endtask

    // overfill the table so the oldest records get dropped in order
    task automatic test_eviction_order();
        send_request(MODE_CLEAR, random_rec(16'h0000, 16'h0000));
        for (int i = 0; i < 20; i++)
            send_request(MODE_ADD, random_rec(16'(100 + i), 16'(900 - i)));
        send_request(MODE_FIND_LOCAL, random_rec(16'd100, 16'd0));
        send_request(MODE_FIND_LOCAL, random_rec(16'd104, 16'd0));
        send_request(MODE_ADD, random_rec(16'd110, 16'd0));
        send_request(MODE_FIND_REMOTE, random_rec(16'd0, 16'd881));
        send_request(MODE_FIND_OLDER, random_rec(16'hffff, 16'd0));
        send_request(MODE_ADD, random_rec(16'd50, 16'd50));
        send_request(MODE_FIND_LOCAL, random_rec(16'd104, 16'd0));
        wait_for_drain();
    endtask

    task automatic send_random_request();
        logic [15:0] key;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            send_request(MODE_ADD, random_rec(pick_seq(recent_local), pick_seq(recent_remote)));
        end else if (r < 63) begin
            send_request(MODE_FIND_LOCAL, random_rec(pick_seq(recent_local), 16'($urandom)));
        end else if (r < 75) begin
            send_request(MODE_FIND_REMOTE, random_rec(16'($urandom), pick_seq(recent_remote)));
        end else if (r < 92) begin
            key = pick_seq(recent_local) + 16'($urandom_range(0, 3));
            send_request(MODE_FIND_OLDER, random_rec(key, 16'($urandom)));
        end else if (r < 94) begin
            send_request(MODE_CLEAR, random_rec(16'($urandom), 16'($urandom)));
        end else begin
            send_request(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                         random_rec(16'($urandom), 16'($urandom)));
        end
    endtask

    // output held off for a long stretch while requests keep coming
    task automatic test_output_hold_off();
        tx_gaps_on = 1'b0;
        hold_off_req = HOLD_OFF_CYCLES;
        repeat (30) send_random_request();
        tx_gaps_on = 1'b1;
        wait_for_drain();
    endtask

    task automatic test_random_mix();
        for (int chunk = 0; chunk < 9; chunk++) begin
            case ($urandom_range(0, 3))
                0: begin tx_gaps_on = 1'b0; rx_stalls_on = 1'b0; end
                1: begin tx_gaps_on = 1'b1; rx_stalls_on = 1'b0; end
                2: begin tx_gaps_on = 1'b0; rx_stalls_on = 1'b1; end
                default: begin tx_gaps_on = 1'b1; rx_stalls_on = 1'b1; end
            endcase
            repeat (96) send_random_request();
            if (chunk % 3 == 2) wait_for_drain();
        end
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        wait_for_drain();
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (m_valid && m_ready) check_result(m_data);
            if (hold_off_req > 0) begin
                stall_left = hold_off_req;
                hold_off_req = 0;
            end
            if (stall_left == 0 && rx_stalls_on && $urandom_range(0, 99) < 20)
                stall_left = pick_pause();
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
        end
        $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        table_init();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_eviction_order();
        test_output_hold_off();
        test_random_mix();
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) begin
            mismatches += pending_results.size();
            $display("%0d results never arrived", pending_results.size());
        end
        $display("covered %0d requests: %0d adds with %0d evictions, %0d lookups with %0d hits",
                 n_add + n_lookup + n_clear + n_spare, n_add, n_evict, n_lookup, n_hits);
        $display("%0d clears, %0d spare-mode requests, %0d results checked, %0d mismatches",
                 n_clear, n_spare, results_checked, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
